// ----- hdl/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Shared constants, the working-variable type and the sequencer states.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // Initial chaining values, h0 in the lowest slot.
    localparam logic [4:0][31:0] C_INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] C_K0 = 32'h5A827999;
    localparam logic [31:0] C_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] C_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] C_K3 = 32'hCA62C1D6;

    localparam logic [7:0]  C_PAD_BYTE  = 8'h80;
    localparam int          C_ROUNDS    = 80;
    localparam logic [6:0]  C_LAST_ROUND = 7'(C_ROUNDS - 1);
    localparam logic [2:0]  C_LAST_WORD  = 3'd4;
    localparam logic [3:0]  C_LEN_WORD   = 4'd14;
    localparam logic [3:0]  C_END_WORD   = 4'd15;

    // Working variables of the compression function.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_abcde;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

// ----- hdl/sha1md_round.sv -----
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects the logical function and constant from the
// round number and produces the next set of working variables.
// ----------------------------------------------------------------------------
module sha1md_round
    import sha1md_pkg::*;
(
    input  logic [6:0]  i_round,
    input  t_abcde      i_v,
    input  logic [31:0] i_w,
    output t_abcde      o_v
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        priority if (i_round < 7'd20) begin
            f = (i_v.b & i_v.c) | (~i_v.b & i_v.d);
            k = C_K0;
        end else if (i_round < 7'd40) begin
            f = i_v.b ^ i_v.c ^ i_v.d;
            k = C_K1;
        end else if (i_round < 7'd60) begin
            f = (i_v.b & i_v.c) | (i_v.b & i_v.d) | (i_v.c & i_v.d);
            k = C_K2;
        end else begin
            f = i_v.b ^ i_v.c ^ i_v.d;
            k = C_K3;
        end
    end

    assign t = {i_v.a[26:0], i_v.a[31:27]} + f + i_v.e + k + i_w;

    assign o_v.a = t;
    assign o_v.b = i_v.a;
    assign o_v.c = {i_v.b[1:0], i_v.b[31:2]};
    assign o_v.d = i_v.c;
    assign o_v.e = i_v.d;

endmodule

// ----- hdl/sha1_message_digest_core.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Hashes a byte stream and returns the 160-bit digest as five words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one message byte per transfer, the first byte of
//   each 32-bit word first. tlast marks the final transfer of a message;
//   tuser set with tlast ends the message without adding the byte in tdata
//   (an empty message when nothing came before). tuser without tlast drops
//   the byte in tdata and does not end the message.
//   Every 64th byte starts a compression of 80 rounds, one per cycle in a
//   single shared round unit, followed by the chaining add. After the final
//   transfer, padding loads one word per cycle (up to 16, or up to 32 with a
//   second block), each padded block is compressed the same way, and the
//   five digest words then follow on the master channel, h0 first, tlast on
//   h4.
//   tready is low from a block's completion until its compression ends, and
//   from a final transfer until the last digest word has been taken.
//   If the receiver stalls, the current word holds; nothing is lost.
//   After the last digest transfer the chaining values and counts return to
//   their initial values. Reset does the same and drops any partial message.
// ----------------------------------------------------------------------------
module sha1_message_digest_core
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    input  logic        s_axis_tuser,   // empty_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);

    t_state             r_state, n_state;
    logic [4:0][31:0]   r_chain, n_chain;
    logic [31:0]        r_w [16];
    logic [31:0]        n_w [16];
    logic [23:0]        r_acc, n_acc;
    t_abcde             r_v, n_v;
    logic [6:0]         r_round, n_round;
    logic [5:0]         r_blk_cnt, n_blk_cnt;
    logic [60:0]        r_msg_cnt, n_msg_cnt;
    logic [2:0]         r_out_idx, n_out_idx;
    logic               r_pad_active, n_pad_active;
    logic               r_marker_done, n_marker_done;
    logic               r_len_hi_done, n_len_hi_done;
    logic               r_len_lo_done, n_len_lo_done;

    t_abcde             round_v;
    logic [31:0]        sched_x;
    logic [31:0]        push_word;
    logic               push;
    logic               s_fire;
    logic               m_fire;
    logic [3:0]         wc;
    logic [31:0]        out_word;

    sha1md_round u_round (
        .i_round (r_round),
        .i_v     (r_v),
        .i_w     (r_w[0]),
        .o_v     (round_v)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign wc            = r_blk_cnt[5:2];

    // The window r_w[0..15] holds W[t..t+15]; the word shifted in is W[t+16].
    assign sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    always_comb begin
        unique case (r_out_idx)
            3'd0:    out_word = r_chain[0];
            3'd1:    out_word = r_chain[1];
            3'd2:    out_word = r_chain[2];
            3'd3:    out_word = r_chain[3];
            3'd4:    out_word = r_chain[4];
            default: out_word = r_chain[0];
        endcase
    end

    assign m_axis_tdata = {5'b0, r_out_idx, out_word};
    assign m_axis_tlast = (r_out_idx == C_LAST_WORD);

    always_comb begin
        n_state       = r_state;
        n_chain       = r_chain;
        n_acc         = r_acc;
        n_v           = r_v;
        n_round       = r_round;
        n_blk_cnt     = r_blk_cnt;
        n_msg_cnt     = r_msg_cnt;
        n_out_idx     = r_out_idx;
        n_pad_active  = r_pad_active;
        n_marker_done = r_marker_done;
        n_len_hi_done = r_len_hi_done;
        n_len_lo_done = r_len_lo_done;
        push          = 1'b0;
        push_word     = 32'h0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_axis_tuser) begin
                        n_blk_cnt = r_blk_cnt + 6'd1;
                        if (r_msg_cnt != '1) begin
                            n_msg_cnt = r_msg_cnt + 61'd1;
                        end
                        if (r_blk_cnt[1:0] == 2'd3) begin
                            push      = 1'b1;
                            push_word = {r_acc, s_axis_tdata};
                        end else begin
                            n_acc = {r_acc[15:0], s_axis_tdata};
                        end
                    end
                    if (s_axis_tlast) begin
                        n_pad_active = 1'b1;
                    end
                    if (!s_axis_tuser && r_blk_cnt == 6'd63) begin
                        n_state = ST_COMP;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push      = 1'b1;
                n_blk_cnt = {wc + 4'd1, 2'b00};
                if (!r_marker_done) begin
                    n_marker_done = 1'b1;
                    unique case (r_blk_cnt[1:0])
                        2'd0: push_word = {C_PAD_BYTE, 24'h0};
                        2'd1: push_word = {r_acc[7:0], C_PAD_BYTE, 16'h0};
                        2'd2: push_word = {r_acc[15:0], C_PAD_BYTE, 8'h0};
                        2'd3: push_word = {r_acc, C_PAD_BYTE};
                    endcase
                end else if (r_len_hi_done) begin
                    // Low half of the bit length closes the final block.
                    push_word     = {r_msg_cnt[28:0], 3'b000};
                    n_len_lo_done = 1'b1;
                end else if (wc == C_LEN_WORD) begin
                    push_word     = r_msg_cnt[60:29];
                    n_len_hi_done = 1'b1;
                end else begin
                    push_word = 32'h0;
                end
                if (wc == C_END_WORD) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                push      = 1'b1;
                push_word = {sched_x[30:0], sched_x[31]};
                n_v       = round_v;
                n_round   = r_round + 7'd1;
                if (r_round == C_LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain[0] = r_chain[0] + r_v.a;
                n_chain[1] = r_chain[1] + r_v.b;
                n_chain[2] = r_chain[2] + r_v.c;
                n_chain[3] = r_chain[3] + r_v.d;
                n_chain[4] = r_chain[4] + r_v.e;
                priority if (r_len_lo_done) begin
                    n_state = ST_OUT;
                end else if (r_pad_active) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == C_LAST_WORD) begin
                        n_out_idx     = 3'd0;
                        n_chain       = C_INIT_CHAIN;
                        n_blk_cnt     = 6'd0;
                        n_msg_cnt     = 61'd0;
                        n_pad_active  = 1'b0;
                        n_marker_done = 1'b0;
                        n_len_hi_done = 1'b0;
                        n_len_lo_done = 1'b0;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Entering a compression loads the working variables from the chain.
        if (n_state == ST_COMP && r_state != ST_COMP) begin
            n_v.a   = r_chain[0];
            n_v.b   = r_chain[1];
            n_v.c   = r_chain[2];
            n_v.d   = r_chain[3];
            n_v.e   = r_chain[4];
            n_round = 7'd0;
        end

        for (int i = 0; i < 15; i++) begin
            n_w[i] = push ? r_w[i + 1] : r_w[i];
        end
        n_w[15] = push ? push_word : r_w[15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain       <= C_INIT_CHAIN;
            r_round       <= 7'd0;
            r_blk_cnt     <= 6'd0;
            r_msg_cnt     <= 61'd0;
            r_out_idx     <= 3'd0;
            r_pad_active  <= 1'b0;
            r_marker_done <= 1'b0;
            r_len_hi_done <= 1'b0;
            r_len_lo_done <= 1'b0;
        end else begin
            r_chain       <= n_chain;
            r_round       <= n_round;
            r_blk_cnt     <= n_blk_cnt;
            r_msg_cnt     <= n_msg_cnt;
            r_out_idx     <= n_out_idx;
            r_pad_active  <= n_pad_active;
            r_marker_done <= n_marker_done;
            r_len_hi_done <= n_len_hi_done;
            r_len_lo_done <= n_len_lo_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_v   <= n_v;
        r_w   <= n_w;
    end

    // A compression always starts and runs on a word-aligned, emptied block.
    a_comp_blk_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_blk_cnt == 6'd0))
        else $error("block count not cleared during compression");

    a_round_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_round <= C_LAST_ROUND))
        else $error("round counter beyond the last round");

    a_last_closes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken straight after a final transfer");

    a_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && m_axis_tlast) |=>
            (r_chain == C_INIT_CHAIN && r_msg_cnt == 61'd0 && r_state == ST_IDLE))
        else $error("state not restored after the digest");

    a_out_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_idx <= C_LAST_WORD && r_len_lo_done))
        else $error("digest word shown before padding finished");

endmodule
